[rtl/gts_pkg.sv]
// Shared types, widths and the corner lattice function for the geodesic subdivider.
// Used by every module of the block; no dependencies.
`default_nettype none
package gts_pkg;
    localparam int CW  = 24;           // coordinate width
    localparam int QW  = 24;           // quadrance width
    localparam int SPW = 4;            // split count width
    localparam int NW  = 28;           // exact corner vector component, signed
    localparam int AW  = 27;           // magnitude of a corner component
    localparam int TW  = 2 * AW;       // square of one component
    localparam int SW  = TW + 2;       // sum of three squares
    localparam int TH  = AW;           // split point of a square for the Q product
    localparam int PW  = TW + QW;      // square times quadrance
    localparam int MAX_SPLIT_DEF = 8;
    localparam int FRAC_BITS_DEF = 20;
    localparam logic [QW-1:0] Q_RESET = 24'd3793775;

    typedef struct packed {
        logic vld;
        logic last;
    } t_tag;

    typedef struct packed {
        logic signed [NW-1:0] x;
        logic signed [NW-1:0] y;
        logic signed [NW-1:0] z;
    } t_vec;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_pt;

    // (n-i)*A + (i-k)*C + k*B, with 0 <= k <= i <= n
    function automatic logic signed [NW-1:0] corner_coord(
        input logic signed [CW-1:0] a,
        input logic signed [CW-1:0] b,
        input logic signed [CW-1:0] c,
        input logic [SPW-1:0] n,
        input logic [SPW-1:0] i,
        input logic [SPW-1:0] k
    );
        logic signed [NW-1:0] ea, eb, ec, ka, kb, kc;
        ea = NW'(a);
        eb = NW'(b);
        ec = NW'(c);
        ka = NW'($signed({1'b0, SPW'(n - i)}));
        kc = NW'($signed({1'b0, SPW'(i - k)}));
        kb = NW'($signed({1'b0, k}));
        return NW'(ea * ka + ec * kc + eb * kb);
    endfunction
endpackage
`default_nettype wire

[rtl/gts_seq.sv]
// Subtriangle sequencer: walks rows and columns and emits three exact corner vectors a cycle.
// Depends on gts_pkg.
`default_nettype none
module gts_seq #(
    parameter int MAX_SPLIT = gts_pkg::MAX_SPLIT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic signed [gts_pkg::CW-1:0] i_a_x,
    input  wire logic signed [gts_pkg::CW-1:0] i_a_y,
    input  wire logic signed [gts_pkg::CW-1:0] i_a_z,
    input  wire logic signed [gts_pkg::CW-1:0] i_b_x,
    input  wire logic signed [gts_pkg::CW-1:0] i_b_y,
    input  wire logic signed [gts_pkg::CW-1:0] i_b_z,
    input  wire logic signed [gts_pkg::CW-1:0] i_c_x,
    input  wire logic signed [gts_pkg::CW-1:0] i_c_y,
    input  wire logic signed [gts_pkg::CW-1:0] i_c_z,
    input  wire logic [gts_pkg::SPW-1:0]       i_split_count,
    output logic                               o_busy,
    output gts_pkg::t_tag                      o_tag,
    output gts_pkg::t_vec                      o_n0,
    output gts_pkg::t_vec                      o_n1,
    output gts_pkg::t_vec                      o_n2
);
    localparam int SPW = gts_pkg::SPW;

    logic                          r_active;
    logic                          r_down;
    logic [SPW-1:0]                r_n, r_i, r_j;
    logic signed [gts_pkg::CW-1:0] r_ax, r_ay, r_az, r_bx, r_by, r_bz, r_cx, r_cy, r_cz;
    gts_pkg::t_tag                 r_tag;
    gts_pkg::t_vec                 r_n0, r_n1, r_n2;

    logic           w_accept;
    logic           w_final;
    logic [SPW-1:0] w_nclamp;
    logic [SPW-1:0] w_i1, w_j1;
    logic [SPW-1:0] w_i_1, w_k_1, w_i_2, w_k_2;

    assign w_accept = i_start && !r_active;
    assign w_final  = !r_down && (r_j == r_i) && (r_i == SPW'(r_n - SPW'(1)));
    assign w_i1     = SPW'(r_i + SPW'(1));
    assign w_j1     = SPW'(r_j + SPW'(1));

    always_comb begin
        if (i_split_count == '0) begin
            w_nclamp = SPW'(1);
        end else if (i_split_count > SPW'(MAX_SPLIT)) begin
            w_nclamp = SPW'(MAX_SPLIT);
        end else begin
            w_nclamp = i_split_count;
        end
        // up: (i,j) (i+1,j+1) (i+1,j); down: (i,j) (i,j+1) (i+1,j+1)
        if (r_down) begin
            w_i_1 = r_i;
            w_k_1 = w_j1;
            w_i_2 = w_i1;
            w_k_2 = w_j1;
        end else begin
            w_i_1 = w_i1;
            w_k_1 = w_j1;
            w_i_2 = w_i1;
            w_k_2 = r_j;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_tag    <= '0;
        end else begin
            r_tag.vld  <= r_active;
            r_tag.last <= r_active && w_final;
            if (w_accept) begin
                r_active <= 1'b1;
            end else if (r_active && w_final) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ax <= i_a_x; r_ay <= i_a_y; r_az <= i_a_z;
            r_bx <= i_b_x; r_by <= i_b_y; r_bz <= i_b_z;
            r_cx <= i_c_x; r_cy <= i_c_y; r_cz <= i_c_z;
            r_n    <= w_nclamp;
            r_i    <= '0;
            r_j    <= '0;
            r_down <= 1'b0;
        end else if (r_active) begin
            if (r_down) begin
                r_down <= 1'b0;
                r_j    <= w_j1;
            end else if (r_j != r_i) begin
                r_down <= 1'b1;
            end else begin
                r_i <= w_i1;
                r_j <= '0;
            end
        end
        r_n0.x <= gts_pkg::corner_coord(r_ax, r_bx, r_cx, r_n, r_i, r_j);
        r_n0.y <= gts_pkg::corner_coord(r_ay, r_by, r_cy, r_n, r_i, r_j);
        r_n0.z <= gts_pkg::corner_coord(r_az, r_bz, r_cz, r_n, r_i, r_j);
        r_n1.x <= gts_pkg::corner_coord(r_ax, r_bx, r_cx, r_n, w_i_1, w_k_1);
        r_n1.y <= gts_pkg::corner_coord(r_ay, r_by, r_cy, r_n, w_i_1, w_k_1);
        r_n1.z <= gts_pkg::corner_coord(r_az, r_bz, r_cz, r_n, w_i_1, w_k_1);
        r_n2.x <= gts_pkg::corner_coord(r_ax, r_bx, r_cx, r_n, w_i_2, w_k_2);
        r_n2.y <= gts_pkg::corner_coord(r_ay, r_by, r_cy, r_n, w_i_2, w_k_2);
        r_n2.z <= gts_pkg::corner_coord(r_az, r_bz, r_cz, r_n, w_i_2, w_k_2);
    end

    assign o_busy = r_active;
    assign o_tag  = r_tag;
    assign o_n0   = r_n0;
    assign o_n1   = r_n1;
    assign o_n2   = r_n2;
endmodule
`default_nettype wire

[rtl/gts_root.sv]
// One coordinate lane: pipelined restoring divide of t*Q*2^F by S, then pipelined integer
// square root, sign and saturation. Depends on gts_pkg.
`default_nettype none
module gts_root #(
    parameter int FRAC_BITS = gts_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire gts_pkg::t_tag                 i_tag,
    input  wire logic                          i_neg,
    input  wire logic                          i_zero,
    input  wire logic [gts_pkg::PW-1:0]        i_prod,
    input  wire logic [gts_pkg::SW-1:0]        i_sum,
    output gts_pkg::t_tag                      o_tag,
    output logic signed [gts_pkg::CW-1:0]      o_coord
);
    localparam int SW  = gts_pkg::SW;
    localparam int QW  = gts_pkg::QW;
    localparam int PW  = gts_pkg::PW;
    localparam int CW  = gts_pkg::CW;
    localparam int QB  = QW + FRAC_BITS;
    localparam int RB  = (QB + 1) / 2;
    localparam int XW  = 2 * RB;
    localparam int EW  = RB + 2;
    localparam int MAG_MAX = (1 << (CW - 1)) - 1;

    // divider stages
    gts_pkg::t_tag  r_dtag  [0:QB];
    logic           r_dneg  [0:QB];
    logic           r_dzero [0:QB];
    logic [SW-1:0]  r_drem  [0:QB];
    logic [SW-1:0]  r_dden  [0:QB];
    logic [QB-1:0]  r_dq    [0:QB];

    // root stages
    gts_pkg::t_tag  r_stag  [0:RB-1];
    logic           r_sneg  [0:RB-1];
    logic           r_szero [0:RB-1];
    logic [XW-1:0]  r_sx    [0:RB-1];
    logic [EW-1:0]  r_srem  [0:RB-1];
    logic [RB-1:0]  r_sroot [0:RB-1];

    gts_pkg::t_tag         r_otag;
    logic signed [CW-1:0]  r_coord;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dtag[0] <= '0;
        end else begin
            r_dtag[0] <= i_tag;
        end
        r_dneg[0]  <= i_neg;
        r_dzero[0] <= i_zero;
        r_drem[0]  <= SW'(i_prod[PW-1:QW]);
        r_dden[0]  <= i_sum;
        r_dq[0]    <= {i_prod[QW-1:0], {FRAC_BITS{1'b0}}};
    end

    for (genvar k = 0; k < QB; k++) begin : g_div
        logic [SW:0] w_x;
        logic        w_ge;
        assign w_x  = {r_drem[k], r_dq[k][QB-1]};
        assign w_ge = w_x >= {1'b0, r_dden[k]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dtag[k+1] <= '0;
            end else begin
                r_dtag[k+1] <= r_dtag[k];
            end
            r_dneg[k+1]  <= r_dneg[k];
            r_dzero[k+1] <= r_dzero[k];
            r_dden[k+1]  <= r_dden[k];
            r_drem[k+1]  <= w_ge ? SW'(w_x - {1'b0, r_dden[k]}) : w_x[SW-1:0];
            r_dq[k+1]    <= {r_dq[k][QB-2:0], w_ge};
        end
    end

    for (genvar k = 0; k < RB; k++) begin : g_sqrt
        gts_pkg::t_tag  w_tag;
        logic           w_neg, w_zero;
        logic [XW-1:0]  w_px;
        logic [EW-1:0]  w_prem;
        logic [RB-1:0]  w_proot;
        logic [EW+1:0]  w_x;
        logic [EW+1:0]  w_trial;
        logic           w_ge;
        if (k == 0) begin : g_first
            assign w_tag   = r_dtag[QB];
            assign w_neg   = r_dneg[QB];
            assign w_zero  = r_dzero[QB];
            assign w_px    = XW'(r_dq[QB]);
            assign w_prem  = '0;
            assign w_proot = '0;
        end else begin : g_next
            assign w_tag   = r_stag[k-1];
            assign w_neg   = r_sneg[k-1];
            assign w_zero  = r_szero[k-1];
            assign w_px    = r_sx[k-1];
            assign w_prem  = r_srem[k-1];
            assign w_proot = r_sroot[k-1];
        end
        assign w_x     = {w_prem, w_px[XW-1:XW-2]};
        assign w_trial = (EW+2)'({w_proot, 2'b01});
        assign w_ge    = w_x >= w_trial;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_stag[k] <= '0;
            end else begin
                r_stag[k] <= w_tag;
            end
            r_sneg[k]  <= w_neg;
            r_szero[k] <= w_zero;
            r_sx[k]    <= {w_px[XW-3:0], 2'b00};
            r_srem[k]  <= w_ge ? EW'(w_x - w_trial) : EW'(w_x);
            r_sroot[k] <= {w_proot[RB-2:0], w_ge};
        end
    end

    logic [CW-1:0] w_mag;
    assign w_mag = (32'(r_sroot[RB-1]) > 32'(MAG_MAX)) ? CW'(MAG_MAX) : CW'(r_sroot[RB-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_otag <= '0;
        end else begin
            r_otag <= r_stag[RB-1];
        end
        if (r_szero[RB-1]) begin
            r_coord <= '0;
        end else if (r_sneg[RB-1]) begin
            r_coord <= $signed(CW'(-w_mag));
        end else begin
            r_coord <= $signed(w_mag);
        end
    end

    assign o_tag   = r_otag;
    assign o_coord = r_coord;
endmodule
`default_nettype wire

[rtl/gts_corner.sv]
// Projection of one exact corner vector onto the sphere: squares, norm, Q products,
// then three coordinate lanes. Depends on gts_pkg and gts_root.
`default_nettype none
module gts_corner #(
    parameter int FRAC_BITS = gts_pkg::FRAC_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire gts_pkg::t_tag          i_tag,
    input  wire gts_pkg::t_vec          i_n,
    input  wire logic [gts_pkg::QW-1:0] i_quad,
    output gts_pkg::t_tag               o_tag,
    output gts_pkg::t_pt                o_pt
);
    localparam int NW = gts_pkg::NW;
    localparam int AW = gts_pkg::AW;
    localparam int TW = gts_pkg::TW;
    localparam int SW = gts_pkg::SW;
    localparam int TH = gts_pkg::TH;
    localparam int QW = gts_pkg::QW;
    localparam int PW = gts_pkg::PW;
    localparam int HW = TH + QW;

    logic signed [NW-1:0] w_n [3];
    assign w_n[0] = i_n.x;
    assign w_n[1] = i_n.y;
    assign w_n[2] = i_n.z;

    gts_pkg::t_tag r1_tag, r2_tag, r3_tag;
    logic [TW-1:0] r1_sq  [3];
    logic          r1_neg [3];
    logic [SW-1:0] r2_sum;
    logic [HW-1:0] r2_pl  [3];
    logic [HW-1:0] r2_ph  [3];
    logic          r2_neg [3];
    logic [SW-1:0] r3_sum;
    logic          r3_zero;
    logic [PW-1:0] r3_prod [3];
    logic          r3_neg  [3];
    logic signed [gts_pkg::CW-1:0] w_coord [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_tag <= '0;
            r2_tag <= '0;
            r3_tag <= '0;
        end else begin
            r1_tag <= i_tag;
            r2_tag <= r1_tag;
            r3_tag <= r2_tag;
        end
        r2_sum  <= SW'(r1_sq[0]) + SW'(r1_sq[1]) + SW'(r1_sq[2]);
        r3_sum  <= r2_sum;
        r3_zero <= (r2_sum == '0);
    end

    for (genvar c = 0; c < 3; c++) begin : g_lane
        logic [AW-1:0] w_abs;
        assign w_abs = w_n[c][NW-1] ? AW'(-w_n[c]) : AW'(w_n[c]);
        always_ff @(posedge i_clk) begin
            r1_neg[c]  <= w_n[c][NW-1];
            r1_sq[c]   <= TW'(w_abs) * TW'(w_abs);
            r2_neg[c]  <= r1_neg[c];
            r2_pl[c]   <= HW'(r1_sq[c][TH-1:0]) * HW'(i_quad);
            r2_ph[c]   <= HW'(r1_sq[c][TW-1:TH]) * HW'(i_quad);
            r3_neg[c]  <= r2_neg[c];
            r3_prod[c] <= (PW'(r2_ph[c]) << TH) + PW'(r2_pl[c]);
        end
    end

    gts_root #(.FRAC_BITS(FRAC_BITS)) u_root_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_tag(r3_tag), .i_neg(r3_neg[0]),
        .i_zero(r3_zero), .i_prod(r3_prod[0]), .i_sum(r3_sum),
        .o_tag(o_tag), .o_coord(w_coord[0])
    );
    gts_root #(.FRAC_BITS(FRAC_BITS)) u_root_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_tag(r3_tag), .i_neg(r3_neg[1]),
        .i_zero(r3_zero), .i_prod(r3_prod[1]), .i_sum(r3_sum),
        .o_tag(), .o_coord(w_coord[1])
    );
    gts_root #(.FRAC_BITS(FRAC_BITS)) u_root_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_tag(r3_tag), .i_neg(r3_neg[2]),
        .i_zero(r3_zero), .i_prod(r3_prod[2]), .i_sum(r3_sum),
        .o_tag(), .o_coord(w_coord[2])
    );

    assign o_pt.x = w_coord[0];
    assign o_pt.y = w_coord[1];
    assign o_pt.z = w_coord[2];
endmodule
`default_nettype wire

[rtl/geodesic_triangle_subdivide_project.sv]
// Each subtriangle passes the sequencer, the corner square, sum and product registers, the
// divider stages, the square-root stages and the output register. One subtriangle per cycle,
// n*n per item (n clamped to 1..8); busy drops at the edge that issues the last subtriangle,
// and no new item is accepted while busy. Results appear for one cycle on o_strobe; the receiver cannot stall.
// Reset (synchronous, active low) idles the sequencer, clears all valid bits, and loads
// the sphere quadrance with its reset value.
`default_nettype none
module geodesic_triangle_subdivide_project #(
    parameter int MAX_SPLIT = gts_pkg::MAX_SPLIT_DEF,
    parameter int FRAC_BITS = gts_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_cfg_we,
    input  wire logic [gts_pkg::QW-1:0]        i_cfg_wdata,
    input  wire logic signed [gts_pkg::CW-1:0] i_a_x,
    input  wire logic signed [gts_pkg::CW-1:0] i_a_y,
    input  wire logic signed [gts_pkg::CW-1:0] i_a_z,
    input  wire logic signed [gts_pkg::CW-1:0] i_b_x,
    input  wire logic signed [gts_pkg::CW-1:0] i_b_y,
    input  wire logic signed [gts_pkg::CW-1:0] i_b_z,
    input  wire logic signed [gts_pkg::CW-1:0] i_c_x,
    input  wire logic signed [gts_pkg::CW-1:0] i_c_y,
    input  wire logic signed [gts_pkg::CW-1:0] i_c_z,
    input  wire logic [gts_pkg::SPW-1:0]       i_split_count,
    output logic                               o_strobe,
    output logic signed [gts_pkg::CW-1:0]      o_v0_x,
    output logic signed [gts_pkg::CW-1:0]      o_v0_y,
    output logic signed [gts_pkg::CW-1:0]      o_v0_z,
    output logic signed [gts_pkg::CW-1:0]      o_v1_x,
    output logic signed [gts_pkg::CW-1:0]      o_v1_y,
    output logic signed [gts_pkg::CW-1:0]      o_v1_z,
    output logic signed [gts_pkg::CW-1:0]      o_v2_x,
    output logic signed [gts_pkg::CW-1:0]      o_v2_y,
    output logic signed [gts_pkg::CW-1:0]      o_v2_z,
    output logic                               o_last_tri
);
    logic [gts_pkg::QW-1:0] r_quad;
    gts_pkg::t_tag          w_stag, w_otag;
    gts_pkg::t_vec          w_n0, w_n1, w_n2;
    gts_pkg::t_pt           w_p0, w_p1, w_p2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quad <= gts_pkg::Q_RESET;
        end else if (i_cfg_we) begin
            r_quad <= i_cfg_wdata;
        end
    end

    gts_seq #(.MAX_SPLIT(MAX_SPLIT)) u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_a_x(i_a_x), .i_a_y(i_a_y), .i_a_z(i_a_z),
        .i_b_x(i_b_x), .i_b_y(i_b_y), .i_b_z(i_b_z),
        .i_c_x(i_c_x), .i_c_y(i_c_y), .i_c_z(i_c_z),
        .i_split_count(i_split_count),
        .o_busy(busy), .o_tag(w_stag), .o_n0(w_n0), .o_n1(w_n1), .o_n2(w_n2)
    );

    gts_corner #(.FRAC_BITS(FRAC_BITS)) u_corner0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_tag(w_stag), .i_n(w_n0), .i_quad(r_quad),
        .o_tag(w_otag), .o_pt(w_p0)
    );
    gts_corner #(.FRAC_BITS(FRAC_BITS)) u_corner1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_tag(w_stag), .i_n(w_n1), .i_quad(r_quad),
        .o_tag(), .o_pt(w_p1)
    );
    gts_corner #(.FRAC_BITS(FRAC_BITS)) u_corner2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_tag(w_stag), .i_n(w_n2), .i_quad(r_quad),
        .o_tag(), .o_pt(w_p2)
    );

    assign o_strobe   = w_otag.vld;
    assign o_last_tri = w_otag.last;
    assign o_v0_x = w_p0.x;
    assign o_v0_y = w_p0.y;
    assign o_v0_z = w_p0.z;
    assign o_v1_x = w_p1.x;
    assign o_v1_y = w_p1.y;
    assign o_v1_z = w_p1.z;
    assign o_v2_x = w_p2.x;
    assign o_v2_y = w_p2.y;
    assign o_v2_z = w_p2.z;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted item");
    a_last_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_tri |-> o_strobe)
        else $error("last_tri without strobe");
    a_seq_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stag.last |-> !busy)
        else $error("sequencer still busy after last subtriangle");
    a_idle_no_tri: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && !start) |=> !w_stag.vld)
        else $error("subtriangle issued while idle");
`endif
endmodule
`default_nettype wire

[test/tb_geodesic_triangle_subdivide_project.sv]
// Self-checking testbench for geodesic_triangle_subdivide_project: directed triangles, then
// random corners and split counts, sphere quadrance changed between phases, results checked exactly.
// Depends on gts_pkg and the block's RTL.
`default_nettype none
module tb_geodesic_triangle_subdivide_project;
    localparam int CW  = gts_pkg::CW;
    localparam int QW  = gts_pkg::QW;
    localparam int SPW = gts_pkg::SPW;

    typedef enum logic [1:0] {K_TRI, K_QUAD} t_kind;

    typedef struct {
        t_kind             kind;
        logic [8:0][CW-1:0] co;     // ax ay az bx by bz cx cy cz
        logic [SPW-1:0]    sp;
        logic [QW-1:0]     qv;
    } t_item;

    typedef struct {
        logic [8:0][CW-1:0] v;
        logic               last;
    } t_tri;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic i_cfg_we = 1'b0;
    logic [QW-1:0] i_cfg_wdata = '0;
    logic [8:0][CW-1:0] drv_co = '0;
    logic [SPW-1:0] i_split_count = '0;
    logic o_strobe, o_last_tri;
    logic signed [CW-1:0] o_v0_x, o_v0_y, o_v0_z, o_v1_x, o_v1_y, o_v1_z;
    logic signed [CW-1:0] o_v2_x, o_v2_y, o_v2_z;

    t_item pending[$];
    t_tri  tri_fifo[$];
    t_item cur;
    logic [QW-1:0] quad_model = gts_pkg::Q_RESET;
    int errors = 0;
    int gap = 0;
    int idle_cnt = 0;

    geodesic_triangle_subdivide_project dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_a_x(drv_co[0]), .i_a_y(drv_co[1]), .i_a_z(drv_co[2]),
        .i_b_x(drv_co[3]), .i_b_y(drv_co[4]), .i_b_z(drv_co[5]),
        .i_c_x(drv_co[6]), .i_c_y(drv_co[7]), .i_c_z(drv_co[8]),
        .i_split_count(i_split_count),
        .o_strobe(o_strobe),
        .o_v0_x(o_v0_x), .o_v0_y(o_v0_y), .o_v0_z(o_v0_z),
        .o_v1_x(o_v1_x), .o_v1_y(o_v1_y), .o_v1_z(o_v1_z),
        .o_v2_x(o_v2_x), .o_v2_y(o_v2_y), .o_v2_z(o_v2_z),
        .o_last_tri(o_last_tri)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [CW-1:0] sphere_coord(longint nc, logic [127:0] s,
                                                   logic [QW-1:0] q);
        logic [127:0] rhs, t;
        logic [63:0] a, lo, hi, mid;
        if (s == 0) return '0;
        a = nc < 0 ? 64'(-nc) : 64'(nc);
        rhs = (128'(a) * 128'(a) * 128'(q)) << gts_pkg::FRAC_BITS_DEF;
        lo = 0;
        hi = 64'h7FFFFF;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            t = 128'(mid) * 128'(mid) * s;
            if (t <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return nc < 0 ? CW'(-lo) : CW'(lo);
    endfunction

    // corner N = n*A + i*(C-A) + k*(B-C), projected
    function automatic logic [2:0][CW-1:0] lattice_point(t_item it, longint n, longint i,
                                                         longint kk, logic [QW-1:0] q);
        longint nv[3];
        logic [127:0] s;
        logic [2:0][CW-1:0] r;
        longint av, bv, cv;
        s = 0;
        for (int c = 0; c < 3; c++) begin
            av = longint'($signed(it.co[c]));
            bv = longint'($signed(it.co[3 + c]));
            cv = longint'($signed(it.co[6 + c]));
            nv[c] = n * av + i * (cv - av) + kk * (bv - cv);
            s += 128'(nv[c] < 0 ? -nv[c] : nv[c]) * 128'(nv[c] < 0 ? -nv[c] : nv[c]);
        end
        for (int c = 0; c < 3; c++) r[c] = sphere_coord(nv[c], s, q);
        return r;
    endfunction

    task automatic push_tri(t_item it, longint n, longint i0, longint k0, longint i1,
                            longint k1, longint i2, longint k2);
        t_tri t;
        logic [2:0][CW-1:0] p;
        p = lattice_point(it, n, i0, k0, quad_model);
        t.v[2:0] = p;
        p = lattice_point(it, n, i1, k1, quad_model);
        t.v[5:3] = p;
        p = lattice_point(it, n, i2, k2, quad_model);
        t.v[8:6] = p;
        t.last = 1'b0;
        tri_fifo = {tri_fifo, t};
    endtask

    task automatic predict_subdivision(t_item it);
        longint n;
        n = it.sp == 0 ? 1 : (it.sp > 8 ? 8 : it.sp);
        for (longint r = 1; r <= n; r++)
            for (longint j = 0; j < r; j++) begin
                push_tri(it, n, r - 1, j, r, j + 1, r, j);
                if (j < r - 1) push_tri(it, n, r - 1, j, r - 1, j + 1, r, j + 1);
            end
        tri_fifo[tri_fifo.size() - 1].last = 1'b1;
    endtask

    task automatic report(string what, logic [CW-1:0] got, logic [CW-1:0] want);
        errors++;
        $display("mismatch %s: got %h expected %h", what, got, want);
    endtask

    function automatic int rand_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 200);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 4);
    endfunction

    // driver
    always @(posedge i_clk) begin
        logic accepted, nx_start, nx_we;
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cfg_we <= 1'b0;
        end else begin
            accepted = start && !busy;
            if (accepted) predict_subdivision(cur);
            nx_start = start && !accepted;
            nx_we = 1'b0;
            if (!nx_start) begin
                if (gap > 0) begin
                    gap--;
                end else if (pending.size() > 0) begin
                    if (pending[0].kind == K_TRI) begin
                        cur = pending.pop_front();
                        drv_co <= cur.co;
                        i_split_count <= cur.sp;
                        nx_start = 1'b1;
                        gap = rand_gap();
                    end else if (tri_fifo.size() == 0 && !busy && !accepted) begin
                        idle_cnt++;
                        if (idle_cnt >= 100) begin
                            cur = pending.pop_front();
                            i_cfg_wdata <= cur.qv;
                            quad_model = cur.qv;
                            nx_we = 1'b1;
                            idle_cnt = 0;
                        end
                    end else begin
                        idle_cnt = 0;
                    end
                end
            end
            start <= nx_start;
            i_cfg_we <= nx_we;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        logic [8:0][CW-1:0] got;
        t_tri want;
        if (i_rst_n && o_strobe) begin
            got = {o_v2_z, o_v2_y, o_v2_x, o_v1_z, o_v1_y, o_v1_x, o_v0_z, o_v0_y, o_v0_x};
            if (tri_fifo.size() == 0) begin
                report("unexpected subtriangle", got[0], '0);
            end else begin
                want = tri_fifo.pop_front();
                for (int c = 0; c < 9; c++)
                    if (got[c] !== want.v[c]) report($sformatf("coord %0d", c), got[c],
                                                     want.v[c]);
                if (o_last_tri !== want.last) report("last_tri", CW'(o_last_tri),
                                                     CW'(want.last));
            end
        end
    end

    task automatic add_tri(logic [8:0][CW-1:0] co, logic [SPW-1:0] sp);
        t_item it;
        it.kind = K_TRI;
        it.co = co;
        it.sp = sp;
        it.qv = '0;
        pending = {pending, it};
    endtask

    task automatic add_quad(logic [QW-1:0] q);
        t_item it;
        it.kind = K_QUAD;
        it.co = '0;
        it.sp = '0;
        it.qv = q;
        pending = {pending, it};
    endtask

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            1: return CW'($signed($urandom_range(0, 8191)) - 4096);
            2: return '0;
            default: return CW'($urandom);
        endcase
    endfunction

    function automatic logic [SPW-1:0] rand_split();
        case ($urandom_range(0, 9))
            0: return SPW'($urandom_range(8, 15));
            1: return SPW'($urandom_range(4, 7));
            default: return SPW'($urandom_range(0, 3));
        endcase
    endfunction

    initial begin
        logic [8:0][CW-1:0] co;
        logic [QW-1:0] qs[5];
        qs = '{24'hFFFFFF, 24'd0, 24'd1, 24'd1048576, gts_pkg::Q_RESET};
        // directed: reset quadrance first
        add_tri({9{24'h000000}}, 4'd0);
        add_tri({9{24'h7FFFFF}}, 4'd1);
        add_tri({9{24'h800000}}, 4'd8);
        add_tri({24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
                 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF}, 4'd15);
        add_tri({24'h0, 24'h0, 24'h100000, 24'h0, 24'h100000, 24'h0,
                 24'h0, 24'h0, 24'h0}, 4'd2);
        add_tri({24'h100000, 24'h0, 24'h0, 24'h0, 24'h100000, 24'h0,
                 24'h0, 24'h0, 24'h100000}, 4'd9);
        add_tri({24'h0, 24'h0, 24'h1, 24'h0, 24'h0, 24'hFFFFFF,
                 24'h0, 24'h1, 24'h0}, 4'd4);
        add_tri({24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000,
                 24'h000001, 24'hFFFFFF, 24'h000000}, 4'd3);
        add_quad(24'hFFFFFF);
        add_tri({9{24'h7FFFFF}}, 4'd1);
        add_tri({24'h0, 24'h0, 24'h1, 24'h0, 24'h1, 24'h0, 24'h1, 24'h0, 24'h0}, 4'd8);
        add_quad(24'd0);
        add_tri({24'h100000, 24'h0, 24'h0, 24'h0, 24'h100000, 24'h0,
                 24'h0, 24'h0, 24'h100000}, 4'd2);
        add_quad(24'd1);
        add_tri({24'h100000, 24'h0, 24'h0, 24'h0, 24'h100000, 24'h0,
                 24'h0, 24'h0, 24'h100000}, 4'd5);
        for (int p = 0; p < 8; p++) begin
            add_quad(p < 5 ? qs[p] : QW'($urandom));
            for (int n = 0; n < 60; n++) begin
                for (int c = 0; c < 9; c++) co[c] = rand_coord();
                add_tri(co, rand_split());
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        wait (pending.size() == 0 && !start && tri_fifo.size() == 0);
        repeat (300) @(posedge i_clk);
        if (tri_fifo.size() != 0) begin
            errors++;
            $display("%0d subtriangles never arrived", tri_fifo.size());
        end
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
rtl/gts_pkg.sv
rtl/gts_seq.sv
rtl/gts_root.sv
rtl/gts_corner.sv
rtl/geodesic_triangle_subdivide_project.sv
test/tb_geodesic_triangle_subdivide_project.sv
